FILE: rtl/rpr_pkg.sv
// shared types, constants and helpers for the random page replacement unit
`default_nettype none

package rpr_pkg;

    // sizes fixed by the field widths
    localparam int PAGES    = 64;
    localparam int FRAMES   = 16;
    localparam int PAGE_W   = $clog2(PAGES);
    localparam int FRAME_W  = $clog2(FRAMES);
    localparam int LIST_IW  = $clog2(FRAMES);
    localparam int CNT_W    = $clog2(FRAMES + 1);
    localparam int FLIM_W   = 5;
    localparam int SWAP_W   = 7;
    localparam int RND_W    = 16;
    localparam int STAT_W   = 32;
    localparam int DIV_CW   = $clog2(RND_W + 1);
    localparam int CFG_IW   = 1;
    localparam int CFG_DW   = 7;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_FRAME_LIMIT = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_SWAP_LIMIT  = 1'b1;

    // configuration reset values
    localparam logic [FLIM_W-1:0] FRAME_LIMIT_RST = 5'd16;
    localparam logic [SWAP_W-1:0] SWAP_LIMIT_RST  = 7'd64;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic resolve;
        logic div_start;
        logic evict;
        logic fetch;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic resolve_ok;
        logic div_done;
        logic out_busy;
    } t_status;

    // saturating increment of a statistics counter
    function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
        sat_inc = (v == {STAT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rpr_div.sv
// bit-serial remainder unit: random value modulo resident count
`default_nettype none

module rpr_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [rpr_pkg::RND_W-1:0]    i_dividend,
    input  wire logic [rpr_pkg::CNT_W-1:0]    i_divisor,
    output logic                              o_done,
    output logic [rpr_pkg::CNT_W-1:0]         o_rem
);

    logic [rpr_pkg::RND_W-1:0]  r_dvd;
    logic [rpr_pkg::CNT_W-1:0]  r_div;
    logic [rpr_pkg::CNT_W-1:0]  r_rem;
    logic [rpr_pkg::CNT_W-1:0]  n_rem;
    logic [rpr_pkg::DIV_CW-1:0] r_cnt;
    logic [rpr_pkg::CNT_W:0]    trial;
    logic [rpr_pkg::CNT_W:0]    diff;

    // one restoring step per cycle
    always_comb begin
        trial = {r_rem, r_dvd[rpr_pkg::RND_W-1]};
        diff  = trial - {1'b0, r_div};
        if (trial >= {1'b0, r_div}) begin
            n_rem = diff[rpr_pkg::CNT_W-1:0];
        end else begin
            n_rem = trial[rpr_pkg::CNT_W-1:0];
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= rpr_pkg::DIV_CW'(rpr_pkg::RND_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // operand and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[rpr_pkg::RND_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = (r_cnt == '0);
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

FILE: rtl/rpr_ctrl.sv
// controller state machine sequencing one page access
`default_nettype none

module rpr_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire rpr_pkg::t_status i_status,
    output rpr_pkg::t_cmd         o_cmd,
    output logic                  o_in_stall
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECIDE = 6'b000010,
        S_DIV    = 6'b000100,
        S_EVICT  = 6'b001000,
        S_FETCH  = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_status.resolve_ok) begin
                    o_cmd.resolve = 1'b1;
                    n_state       = S_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_EVICT;
                end
            end
            S_EVICT: begin
                o_cmd.evict = 1'b1;
                n_state     = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // no transaction is taken while in reset
    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;

endmodule

`default_nettype wire

FILE: rtl/rpr_dp.sv
// datapath: page tables, resident list, swap set, counters and result register
`default_nettype none

module rpr_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rpr_pkg::t_cmd                 i_cmd,
    output rpr_pkg::t_status                   o_status,
    input  wire logic [rpr_pkg::PAGE_W-1:0]    i_page_number,
    input  wire logic [rpr_pkg::RND_W-1:0]     i_random_value,
    input  wire logic                          i_cfg_valid,
    input  wire logic [rpr_pkg::CFG_IW-1:0]    i_cfg_index,
    input  wire logic [rpr_pkg::CFG_DW-1:0]    i_cfg_data,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output logic                               o_hit,
    output logic                               o_fault,
    output logic                               o_victim_valid,
    output logic [rpr_pkg::PAGE_W-1:0]         o_victim_page,
    output logic [rpr_pkg::FRAME_W-1:0]        o_frame,
    output logic                               o_error,
    output logic [rpr_pkg::STAT_W-1:0]         o_hit_count,
    output logic [rpr_pkg::STAT_W-1:0]         o_fault_count
);

    localparam int PAGE_W  = rpr_pkg::PAGE_W;
    localparam int FRAME_W = rpr_pkg::FRAME_W;
    localparam int CNT_W   = rpr_pkg::CNT_W;
    localparam int SWAP_W  = rpr_pkg::SWAP_W;
    localparam int FRAMES  = rpr_pkg::FRAMES;
    localparam int PAGES   = rpr_pkg::PAGES;
    localparam int STAT_W  = rpr_pkg::STAT_W;

    // transaction operands
    logic [PAGE_W-1:0]         r_page;
    logic [rpr_pkg::RND_W-1:0] r_rnd;

    // page state
    logic [PAGES-1:0]   r_present;
    logic [PAGES-1:0]   r_swap;
    logic [PAGE_W-1:0]  r_list [FRAMES];
    logic [PAGE_W-1:0]  n_list [FRAMES];
    logic [CNT_W-1:0]   r_count;
    logic [SWAP_W-1:0]  r_swap_count;
    logic [STAT_W-1:0]  r_hits;
    logic [STAT_W-1:0]  r_faults;
    logic               r_error;

    // configuration
    logic [rpr_pkg::FLIM_W-1:0] r_frame_limit;
    logic [SWAP_W-1:0]          r_swap_limit;
    logic [CNT_W-1:0]           limit;

    // frame table memory
    logic [FRAME_W-1:0] r_frames [PAGES];
    logic [FRAME_W-1:0] r_rdata;
    logic [PAGE_W-1:0]  rd_addr;
    logic               wr_en;
    logic [FRAME_W-1:0] wr_data;

    // decision and eviction terms
    logic                      is_hit;
    logic                      is_fill;
    logic                      is_fail;
    logic [CNT_W-1:0]          div_rem;
    logic                      div_done;
    logic [rpr_pkg::LIST_IW-1:0] slot_idx;
    logic [PAGE_W-1:0]         victim;
    logic [PAGE_W-1:0]         r_victim;
    logic [SWAP_W-1:0]         sc_inc;
    logic [SWAP_W-1:0]         n_sc_evict;

    // pending result
    logic               r_res_hit;
    logic               r_res_fault;
    logic               r_res_vvalid;
    logic [PAGE_W-1:0]  r_res_vpage;
    logic [FRAME_W-1:0] r_res_frame;

    // clamp the frame limit to 1..FRAMES
    always_comb begin
        if (r_frame_limit == '0) begin
            limit = CNT_W'(1);
        end else if (CNT_W'(r_frame_limit) > CNT_W'(FRAMES)) begin
            limit = CNT_W'(FRAMES);
        end else begin
            limit = CNT_W'(r_frame_limit);
        end
    end

    // classify the access
    assign is_hit  = !r_error && r_present[r_page];
    assign is_fill = !r_error && !r_present[r_page] && (r_count < limit);
    assign is_fail = !r_error && !r_present[r_page] && !(r_count < limit)
                     && ((r_swap_count >= r_swap_limit) || (r_count == '0));

    assign o_status.resolve_ok = r_error || is_hit || is_fill || is_fail;
    assign o_status.div_done   = div_done;
    assign o_status.out_busy   = o_out_valid && i_out_stall;

    // victim slot from random value modulo resident count
    rpr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_rnd),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign slot_idx = div_rem[rpr_pkg::LIST_IW-1:0];
    assign victim   = r_list[slot_idx];

    // close up the list behind the victim and append the new page
    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            n_list[i] = r_list[i];
        end
        for (int i = 0; i < FRAMES - 1; i++) begin
            if ((CNT_W'(i) >= div_rem) && (CNT_W'(i + 1) < r_count)) begin
                n_list[i] = r_list[i + 1];
            end
        end
        for (int i = 0; i < FRAMES; i++) begin
            if (CNT_W'(i) == r_count - 1'b1) begin
                n_list[i] = r_page;
            end
        end
    end

    // swap count after an eviction
    always_comb begin
        sc_inc = r_swap_count + SWAP_W'(!r_swap[victim]);
        if (r_swap[r_page] && (sc_inc != '0)) begin
            n_sc_evict = sc_inc - 1'b1;
        end else begin
            n_sc_evict = sc_inc;
        end
    end

    // frame table port control
    assign rd_addr = i_cmd.evict ? victim : i_page_number;
    assign wr_en   = (i_cmd.resolve && is_fill) || i_cmd.fetch;
    assign wr_data = i_cmd.fetch ? r_rdata : r_count[FRAME_W-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_frames[r_page] <= wr_data;
        end
        r_rdata <= r_frames[rd_addr];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_limit <= rpr_pkg::FRAME_LIMIT_RST;
            r_swap_limit  <= rpr_pkg::SWAP_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rpr_pkg::CFG_FRAME_LIMIT: r_frame_limit <= i_cfg_data[rpr_pkg::FLIM_W-1:0];
                rpr_pkg::CFG_SWAP_LIMIT:  r_swap_limit  <= i_cfg_data[SWAP_W-1:0];
                default: ;
            endcase
        end
    end

    // transaction operands
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_page <= i_page_number;
            r_rnd  <= i_random_value;
        end
        if (i_cmd.evict) begin
            r_victim <= victim;
        end
    end

    // resident list
    always_ff @(posedge i_clk) begin
        if (i_cmd.resolve && is_fill) begin
            r_list[r_count[rpr_pkg::LIST_IW-1:0]] <= r_page;
        end else if (i_cmd.evict) begin
            r_list <= n_list;
        end
    end

    // page state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present    <= '0;
            r_swap       <= '0;
            r_count      <= '0;
            r_swap_count <= '0;
            r_hits       <= '0;
            r_faults     <= '0;
            r_error      <= 1'b0;
        end else if (i_cmd.resolve) begin
            if (is_hit) begin
                r_hits <= rpr_pkg::sat_inc(r_hits);
            end else if (is_fill) begin
                r_faults           <= rpr_pkg::sat_inc(r_faults);
                r_present[r_page]  <= 1'b1;
                r_count            <= r_count + 1'b1;
                if (r_swap[r_page]) begin
                    r_swap[r_page] <= 1'b0;
                    if (r_swap_count != '0) begin
                        r_swap_count <= r_swap_count - 1'b1;
                    end
                end
            end else if (is_fail) begin
                r_error <= 1'b1;
            end
        end else if (i_cmd.evict) begin
            r_faults          <= rpr_pkg::sat_inc(r_faults);
            r_swap_count      <= n_sc_evict;
            r_swap[victim]    <= 1'b1;
            r_swap[r_page]    <= 1'b0;
            r_present[victim] <= 1'b0;
            r_present[r_page] <= 1'b1;
        end
    end

    // pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.resolve) begin
            r_res_hit    <= is_hit;
            r_res_fault  <= is_fill || is_fail;
            r_res_vvalid <= 1'b0;
            r_res_vpage  <= '0;
            if (is_hit) begin
                r_res_frame <= r_rdata;
            end else if (is_fill) begin
                r_res_frame <= r_count[FRAME_W-1:0];
            end else begin
                r_res_frame <= '0;
            end
        end else if (i_cmd.fetch) begin
            r_res_hit    <= 1'b0;
            r_res_fault  <= 1'b1;
            r_res_vvalid <= 1'b1;
            r_res_vpage  <= r_victim;
            r_res_frame  <= r_rdata;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_hit          <= r_res_hit;
            o_fault        <= r_res_fault;
            o_victim_valid <= r_res_vvalid;
            o_victim_page  <= r_res_vpage;
            o_frame        <= r_res_frame;
            o_error        <= r_error;
            o_hit_count    <= r_hits;
            o_fault_count  <= r_faults;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/random_page_replacement_top.sv
// top level of the random page replacement unit
//
// channel   direction  handshake                    payload
// in        input      i_in_valid / o_in_stall      i_page_number, i_random_value
// out       output     o_out_valid / i_out_stall    o_hit .. o_fault_count
// cfg       input      i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// one access at a time; a hit, a fill into a free frame or a swap-full access
// is resolved straight from the decide state; an eviction waits on the
// remainder unit, which retires one bit of the 16-bit random value per cycle
// the result sits in an output register; a stalled result holds the controller
// before its next load, while the next access is already being processed
// synchronous active-low reset clears the page and swap sets and counts
// and returns both limits to their reset values
`default_nettype none

module random_page_replacement_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [rpr_pkg::PAGE_W-1:0]      i_page_number,
    input  wire logic [rpr_pkg::RND_W-1:0]       i_random_value,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [rpr_pkg::CFG_IW-1:0]      i_cfg_index,
    input  wire logic [rpr_pkg::CFG_DW-1:0]      i_cfg_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic                                 o_hit,
    output logic                                 o_fault,
    output logic                                 o_victim_valid,
    output logic [rpr_pkg::PAGE_W-1:0]           o_victim_page,
    output logic [rpr_pkg::FRAME_W-1:0]          o_frame,
    output logic                                 o_error,
    output logic [rpr_pkg::STAT_W-1:0]           o_hit_count,
    output logic [rpr_pkg::STAT_W-1:0]           o_fault_count
);

    rpr_pkg::t_cmd    cmd;
    rpr_pkg::t_status status;

    // registers take a write on any cycle out of reset
    assign o_cfg_ready = i_rst_n;

    // sequencing
    rpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // storage and arithmetic
    rpr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_page_number  (i_page_number),
        .i_random_value (i_random_value),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_hit          (o_hit),
        .o_fault        (o_fault),
        .o_victim_valid (o_victim_valid),
        .o_victim_page  (o_victim_page),
        .o_frame        (o_frame),
        .o_error        (o_error),
        .o_hit_count    (o_hit_count),
        .o_fault_count  (o_fault_count)
    );

endmodule

`default_nettype wire

FILE: test/tb_random_page_replacement_top.sv
// testbench for the random page replacement unit: self-checking against a behavioral predictor
`timescale 1ns / 100ps

module tb_random_page_replacement_top;

    localparam int PAGES   = rpr_pkg::PAGES;
    localparam int FRAMES  = rpr_pkg::FRAMES;
    localparam int PAGE_W  = rpr_pkg::PAGE_W;
    localparam int FRAME_W = rpr_pkg::FRAME_W;
    localparam int RND_W   = rpr_pkg::RND_W;
    localparam int STAT_W  = rpr_pkg::STAT_W;
    localparam int FLIM_W  = rpr_pkg::FLIM_W;
    localparam int SWAP_W  = rpr_pkg::SWAP_W;
    localparam int CFG_IW  = rpr_pkg::CFG_IW;
    localparam int CFG_DW  = rpr_pkg::CFG_DW;

    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 30;

    // one result transaction as seen on the output ports
    typedef struct packed {
        logic              hit;
        logic              fault;
        logic              victim_valid;
        logic [PAGE_W-1:0] victim_page;
        logic [FRAME_W-1:0] frame;
        logic              error;
        logic [STAT_W-1:0] hit_count;
        logic [STAT_W-1:0] fault_count;
    } t_access_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [PAGE_W-1:0]   i_page_number;
    logic [RND_W-1:0]    i_random_value;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_IW-1:0]   i_cfg_index;
    logic [CFG_DW-1:0]   i_cfg_data;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic                o_hit;
    logic                o_fault;
    logic                o_victim_valid;
    logic [PAGE_W-1:0]   o_victim_page;
    logic [FRAME_W-1:0]  o_frame;
    logic                o_error;
    logic [STAT_W-1:0]   o_hit_count;
    logic [STAT_W-1:0]   o_fault_count;

    // expected results in order, plus run bookkeeping
    t_access_result pending_results[$];
    int             mismatch_count = 0;
    int             idle_cycles = 0;
    int             stall_left = 0;
    logic           gaps_on = 1'b0;
    logic           stalls_on = 1'b0;

    // mirror of the page table, swap set and configuration
    logic              page_resident[PAGES];
    logic [FRAME_W-1:0] page_frame[PAGES];
    logic [PAGE_W-1:0] resident_order[FRAMES];
    int unsigned       resident_num;
    logic              page_swapped[PAGES];
    int unsigned       swapped_num;
    logic [STAT_W-1:0] hit_total;
    logic [STAT_W-1:0] fault_total;
    logic              swap_full_seen;
    logic [FLIM_W-1:0] frame_cap;
    logic [SWAP_W-1:0] swap_cap;

    random_page_replacement_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_page_number  (i_page_number),
        .i_random_value (i_random_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hit          (o_hit),
        .o_fault        (o_fault),
        .o_victim_valid (o_victim_valid),
        .o_victim_page  (o_victim_page),
        .o_frame        (o_frame),
        .o_error        (o_error),
        .o_hit_count    (o_hit_count),
        .o_fault_count  (o_fault_count)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // effective frame limit after clamping
    function automatic int unsigned frame_room();
        int unsigned lim;
        lim = frame_cap;
        if (lim < 1)
            lim = 1;
        if (lim > FRAMES)
            lim = FRAMES;
        return lim;
    endfunction

    // page access predictor: updates the mirror and returns the expected result
    function automatic t_access_result predict_access(input logic [PAGE_W-1:0] pg,
                                                      input logic [RND_W-1:0] rv);
        t_access_result r;
        int unsigned    slot;
        int unsigned    k;
        logic [PAGE_W-1:0] vic;
        r = '0;
        if (!swap_full_seen) begin
            if (page_resident[pg]) begin
                r.hit = 1'b1;
                if (hit_total != '1)
                    hit_total = hit_total + 1'b1;
                r.frame = page_frame[pg];
            end else begin
                r.fault = 1'b1;
                if (resident_num < frame_room()) begin
                    // free frame available
                    if (fault_total != '1)
                        fault_total = fault_total + 1'b1;
                    page_frame[pg] = FRAME_W'(resident_num);
                    r.frame = FRAME_W'(resident_num);
                    if (page_swapped[pg]) begin
                        page_swapped[pg] = 1'b0;
                        if (swapped_num > 0)
                            swapped_num--;
                    end
                    resident_order[resident_num] = pg;
                    resident_num++;
                    page_resident[pg] = 1'b1;
                end else if (swapped_num >= swap_cap || resident_num == 0) begin
                    swap_full_seen = 1'b1;
                end else begin
                    // evict a random list slot and close the gap
                    slot = rv % resident_num;
                    vic = resident_order[slot];
                    if (fault_total != '1)
                        fault_total = fault_total + 1'b1;
                    for (k = slot; k + 1 < resident_num; k++)
                        resident_order[k] = resident_order[k + 1];
                    if (!page_swapped[vic]) begin
                        page_swapped[vic] = 1'b1;
                        swapped_num++;
                    end
                    if (page_swapped[pg]) begin
                        page_swapped[pg] = 1'b0;
                        if (swapped_num > 0)
                            swapped_num--;
                    end
                    page_resident[vic] = 1'b0;
                    page_frame[pg] = page_frame[vic];
                    r.frame = page_frame[pg];
                    resident_order[resident_num - 1] = pg;
                    page_resident[pg] = 1'b1;
                    r.victim_valid = 1'b1;
                    r.victim_page = vic;
                end
            end
        end
        r.error = swap_full_seen;
        if (swap_full_seen)
            r.frame = '0;
        r.hit_count = hit_total;
        r.fault_count = fault_total;
        return r;
    endfunction

    // mirror state after reset
    task automatic clear_mirror();
        for (int p = 0; p < PAGES; p++) begin
            page_resident[p] = 1'b0;
            page_swapped[p] = 1'b0;
            page_frame[p] = '0;
        end
        for (int f = 0; f < FRAMES; f++)
            resident_order[f] = '0;
        resident_num = 0;
        swapped_num = 0;
        hit_total = '0;
        fault_total = '0;
        swap_full_seen = 1'b0;
        frame_cap = rpr_pkg::FRAME_LIMIT_RST;
        swap_cap = rpr_pkg::SWAP_LIMIT_RST;
    endtask

    // send one access transaction; valid stays high for a back-to-back follower
    task automatic send_access(input logic [PAGE_W-1:0] pg, input logic [RND_W-1:0] rv);
        int             gap;
        t_access_result exp_res;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_page_number <= pg;
        i_random_value <= rv;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        exp_res = predict_access(pg, rv);
        pending_results.insert(pending_results.size(), exp_res);
    endtask

    // stop sending and wait for every expected result
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // one configuration write, only while idle
    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (idx == rpr_pkg::CFG_FRAME_LIMIT)
            frame_cap = data[FLIM_W-1:0];
        else
            swap_cap = data[SWAP_W-1:0];
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // first fills into free frames and hits on them
    task automatic test_fill_and_hit();
        send_access('0, '0);
        send_access('1, '1);
        send_access('0, 16'h1234);
        send_access('1, '0);
        settle();
    endtask

    // frame limit of zero acts as one and below the resident count forces evictions;
    // an oversized limit acts as the full frame count
    task automatic test_limit_clamp();
        write_reg(rpr_pkg::CFG_FRAME_LIMIT, 7'd0);
        send_access(6'd5, '1);
        send_access(6'd63, '0);
        send_access(6'd0, 16'd1);
        settle();
        write_reg(rpr_pkg::CFG_FRAME_LIMIT, 7'h7f);
        send_access(6'd10, '0);
        send_access(6'd20, '1);
        send_access(6'd10, 16'h1234);
        settle();
    endtask

    // random accesses over several limit settings, mostly from a hot working set
    task automatic test_random_mix();
        logic [CFG_DW-1:0] frame_plan[5];
        logic [CFG_DW-1:0] swap_plan[5];
        logic [PAGE_W-1:0] base;
        logic [PAGE_W-1:0] pg;
        logic [RND_W-1:0]  rv;
        int                roll;
        frame_plan = '{7'd16, 7'd4, 7'h20, 7'h7f, 7'd0};
        swap_plan = '{7'd64, 7'd127, 7'd63, 7'd100, 7'd64};
        frame_plan[4] = CFG_DW'($urandom_range(1, FRAMES));
        for (int ph = 0; ph < 5; ph++) begin
            settle();
            write_reg(rpr_pkg::CFG_FRAME_LIMIT, frame_plan[ph]);
            write_reg(rpr_pkg::CFG_SWAP_LIMIT, swap_plan[ph]);
            base = PAGE_W'($urandom_range(0, PAGES - 1));
            for (int n = 0; n < 100; n++) begin
                // change idling pattern every so often
                if (n % 25 == 0) begin
                    gaps_on = ($urandom_range(0, 3) != 0);
                    stalls_on <= ($urandom_range(0, 3) != 0);
                end
                // let everything drain once mid phase
                if (n == 50)
                    settle();
                if ($urandom_range(0, 99) < 65)
                    pg = PAGE_W'(base + $urandom_range(0, frame_room() + 3));
                else
                    pg = PAGE_W'($urandom_range(0, PAGES - 1));
                roll = $urandom_range(0, 19);
                if (roll == 0)
                    rv = '0;
                else if (roll == 1)
                    rv = '1;
                else
                    rv = RND_W'($urandom_range(0, 65535));
                send_access(pg, rv);
            end
        end
        settle();
        gaps_on = 1'b1;
        stalls_on <= 1'b1;
    endtask

    // swap set full: sticky error, then frozen state
    task automatic test_swap_full();
        logic [PAGE_W-1:0] target;
        logic [PAGE_W-1:0] keeper;
        logic              found;
        write_reg(rpr_pkg::CFG_FRAME_LIMIT, 7'd1);
        write_reg(rpr_pkg::CFG_SWAP_LIMIT, 7'd0);
        // prefer a page sitting in swap, so the full check comes first
        found = 1'b0;
        target = '0;
        for (int p = 0; p < PAGES; p++) begin
            if (!found && page_swapped[p]) begin
                target = PAGE_W'(p);
                found = 1'b1;
            end
        end
        for (int p = 0; p < PAGES; p++) begin
            if (!found && !page_resident[p]) begin
                target = PAGE_W'(p);
                found = 1'b1;
            end
        end
        keeper = resident_order[0];
        send_access(target, RND_W'($urandom_range(0, 65535)));
        send_access(keeper, '0);
        send_access(PAGE_W'($urandom_range(0, PAGES - 1)), '1);
        settle();
    endtask

    // random output stall, short bursts mostly
    always @(posedge i_clk) begin
        if (!stalls_on) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                          : $urandom_range(10, 40);
        end
    end

    // field compare, every mismatch reported
    task automatic check_field(input string name, input logic [STAT_W-1:0] want,
                               input logic [STAT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_access_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transaction, expected none actual hit=%0d fault=%0d",
                         $time, o_hit, o_fault);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("hit", STAT_W'(want.hit), STAT_W'(o_hit));
                check_field("fault", STAT_W'(want.fault), STAT_W'(o_fault));
                check_field("victim_valid", STAT_W'(want.victim_valid),
                            STAT_W'(o_victim_valid));
                check_field("victim_page", STAT_W'(want.victim_page), STAT_W'(o_victim_page));
                check_field("frame", STAT_W'(want.frame), STAT_W'(o_frame));
                check_field("error", STAT_W'(want.error), STAT_W'(o_error));
                check_field("hit_count", want.hit_count, o_hit_count);
                check_field("fault_count", want.fault_count, o_fault_count);
            end
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // test sequence
    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_page_number = '0;
        i_random_value = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = rpr_pkg::CFG_FRAME_LIMIT;
        i_cfg_data = '0;
        clear_mirror();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_fill_and_hit();
        test_limit_clamp();
        test_random_mix();
        test_swap_full();

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
